[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[rtl/kos_pkg.sv]
package kos_pkg;

    localparam int MAX_RANK   = 16;
    localparam int IDX_W      = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int CNT_W      = $clog2(MAX_RANK + 1);
    localparam int DATA_W     = 32;
    localparam int RANK_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_LARGEST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK_K         = 1'b1;

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic [CNT_W-1:0]         count_t;
    typedef logic [IDX_W-1:0]         index_t;

    // Clamp rank into 1..MAX_RANK.
    function automatic count_t effective_rank(input logic [RANK_W-1:0] rank);
        int r;
        r = int'(rank);
        if (r == 0)
            r = 1;
        if (r > MAX_RANK)
            r = MAX_RANK;
        return CNT_W'(r);
    endfunction

endpackage

[rtl/kth_order_statistic_select.sv]
// k-th order statistic selector over a stream of signed 32-bit sets.
// Input channel (in_valid/in_ready): sample_value plus set_end, which marks
// the final sample of a set. Output channel (out_valid/out_ready): kth_value
// and too_few, one transfer per set, on the sample marked set_end.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0 writes
// select_largest, index 1 writes rank_k. Write it only while the block idles.
// Samples are kept in a 16-entry register file; the top entry (greatest in
// smallest mode, least in largest mode) is found by a scan that walks the held
// entries through a single signed comparator, one entry per cycle.
// Per sample: while the set is still filling, the sample is appended; once
// full, a scan over the held entries, then a compare and replace step; a
// set_end sample adds a second scan, then the result load, which waits while
// the output register still holds a result that the receiver has not taken.
// in_ready is high only in the idle state; the result goes to an output
// register, so a stalled receiver holds only the next set_end sample.
// Reset clears the held count, the output valid flag and the configuration
// (smallest mode, rank 1); heap contents are undefined until written.
`include "assert_macros.svh"

module kth_order_statistic_select (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [kos_pkg::DATA_W-1:0]     sample_value,
    input  logic                                  set_end,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [kos_pkg::DATA_W-1:0]     kth_value,
    output logic                                  too_few,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [kos_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [kos_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import kos_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SCAN    = 2'd1;
    localparam logic [1:0] ST_REPLACE = 2'd2;
    localparam logic [1:0] ST_EMIT    = 2'd3;

    logic [1:0]        state_reg, state_next;
    sample_t           heap_reg [MAX_RANK];
    count_t            held_count_reg, held_count_next;
    sample_t           sample_reg, sample_next;
    logic              last_reg, last_next;
    logic              phase_reg, phase_next;     // 0: scan before replace, 1: scan for result
    index_t            scan_idx_reg, scan_idx_next;
    sample_t           best_val_reg, best_val_next;
    index_t            best_idx_reg, best_idx_next;
    logic              out_valid_reg, out_valid_next;
    sample_t           kth_value_reg, kth_value_next;
    logic              too_few_reg, too_few_next;
    logic              select_largest_reg;
    logic [RANK_W-1:0] rank_k_reg;

    count_t            rank_eff;
    sample_t           rd_val;
    sample_t           cmp_a, cmp_b;
    logic              cmp_less;
    logic              wr_en;
    index_t            wr_idx;
    sample_t           wr_val;
    logic              in_fire;
    logic              scan_done;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign kth_value = kth_value_reg;
    assign too_few   = too_few_reg;

    assign rank_eff  = effective_rank(rank_k_reg);
    assign rd_val    = heap_reg[scan_idx_reg];
    assign scan_done = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == held_count_reg);

    // Shared comparator: the scan looks for a better top, the replace step
    // checks whether the new sample beats the top.
    always_comb
    begin
        if (state_reg == ST_REPLACE)
        begin
            cmp_a = select_largest_reg ? best_val_reg : sample_reg;
            cmp_b = select_largest_reg ? sample_reg   : best_val_reg;
        end
        else
        begin
            cmp_a = select_largest_reg ? rd_val       : best_val_reg;
            cmp_b = select_largest_reg ? best_val_reg : rd_val;
        end
        cmp_less = (cmp_a < cmp_b);
    end

    always_comb
    begin
        state_next      = state_reg;
        held_count_next = held_count_reg;
        sample_next     = sample_reg;
        last_next       = last_reg;
        phase_next      = phase_reg;
        scan_idx_next   = scan_idx_reg;
        best_val_next   = best_val_reg;
        best_idx_next   = best_idx_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        kth_value_next  = kth_value_reg;
        too_few_next    = too_few_reg;
        wr_en           = 1'b0;
        wr_idx          = held_count_reg[IDX_W-1:0];
        wr_val          = sample_value;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    sample_next   = sample_value;
                    last_next     = set_end;
                    scan_idx_next = '0;
                    if (held_count_reg < rank_eff)
                    begin
                        // still filling: append the sample
                        wr_en           = 1'b1;
                        held_count_next = held_count_reg + CNT_W'(1);
                        phase_next      = 1'b1;
                        if (set_end)
                            state_next = ST_SCAN;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == '0 || cmp_less)
                begin
                    best_val_next = rd_val;
                    best_idx_next = scan_idx_reg;
                end
                if (scan_done)
                    state_next = phase_reg ? ST_EMIT : ST_REPLACE;
                else
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
            end
            ST_REPLACE:
            begin
                if (cmp_less)
                begin
                    wr_en  = 1'b1;
                    wr_idx = best_idx_reg;
                    wr_val = sample_reg;
                end
                scan_idx_next = '0;
                phase_next    = 1'b1;
                state_next    = last_reg ? ST_SCAN : ST_IDLE;
            end
            ST_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    kth_value_next  = best_val_reg;
                    too_few_next    = (held_count_reg < rank_eff);
                    held_count_next = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            held_count_reg     <= '0;
            phase_reg          <= 1'b0;
            out_valid_reg      <= 1'b0;
            select_largest_reg <= 1'b0;
            rank_k_reg         <= RANK_W'(1);
        end
        else
        begin
            state_reg      <= state_next;
            held_count_reg <= held_count_next;
            phase_reg      <= phase_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SELECT_LARGEST: select_largest_reg <= cfg_data[0];
                    CFG_RANK_K:         rank_k_reg <= cfg_data[RANK_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        last_reg      <= last_next;
        scan_idx_reg  <= scan_idx_next;
        best_val_reg  <= best_val_next;
        best_idx_reg  <= best_idx_next;
        kth_value_reg <= kth_value_next;
        too_few_reg   <= too_few_next;
        if (wr_en)
            heap_reg[wr_idx] <= wr_val;
    end

    `ASSERT_CLK(a_held_bounded, held_count_reg <= CNT_W'(MAX_RANK),
        "held count exceeds heap depth")
    `ASSERT_CLK(a_scan_in_range,
        (state_reg != ST_SCAN) || (CNT_W'(scan_idx_reg) < held_count_reg),
        "scan index past held entries")
    `ASSERT_NEXT(a_emit_clears,
        (state_reg == ST_EMIT) && (!out_valid_reg || out_ready),
        (held_count_reg == '0) && out_valid_reg && (state_reg == ST_IDLE),
        "result load did not clear the set")

endmodule
